// File: hw/rtl/rcnt_pkg.sv
// ----------------------------------------------------------------------------
// Root counter package
// Item types, register offsets, mode bit positions and reset values shared by
// the channel interfaces and the three-channel root counter.
// ----------------------------------------------------------------------------
package rcnt_pkg;

    localparam int TIMER_COUNT = 3;
    localparam int PERIOD_W    = 12;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_READ  = 2'd1,
        OP_WRITE = 2'd2
    } t_op;

    localparam logic [1:0] SIZE_BYTE  = 2'd0;

    localparam logic [3:0] OFF_VALUE  = 4'h0;
    localparam logic [3:0] OFF_MODE   = 4'h4;
    localparam logic [3:0] OFF_TARGET = 4'h8;

    localparam logic [1:0] TIMER_NONE = 2'd3;

    localparam int MODE_SYNC_EN    = 0;
    localparam int MODE_RESET_TGT  = 3;
    localparam int MODE_SRC_LO     = 8;
    localparam int MODE_SRC_HI     = 9;
    localparam int MODE_IRQ_OFF    = 10;
    localparam int MODE_HIT_TARGET = 11;
    localparam int MODE_HIT_FFFF   = 12;

    localparam logic [15:0] WRAP_POINT = 16'hFFFF;

    localparam logic [PERIOD_W-1:0] PERIOD_RESET [TIMER_COUNT] = '{
        12'd3, 12'd2147, 12'd8
    };

    typedef struct packed {
        logic [1:0]  operation;
        logic [5:0]  reg_address;
        logic [1:0]  access_size;
        logic [15:0] write_data;
    } t_in_item;

    typedef struct packed {
        logic [15:0] read_data;
        logic [2:0]  irq_pulses;
        logic        bad_access;
    } t_out_item;

    typedef struct packed {
        logic [1:0]          index;
        logic [PERIOD_W-1:0] data;
    } t_cfg_item;

endpackage

// File: hw/rtl/rcnt_if.sv
// ----------------------------------------------------------------------------
// Root counter channels
// Valid/ready channels for input items, result items and period writes.
// ----------------------------------------------------------------------------
interface rcnt_item_if import rcnt_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface rcnt_result_if import rcnt_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface rcnt_cfg_if import rcnt_pkg::*; ();
    logic      valid;
    logic      ready;
    t_cfg_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// File: hw/rtl/three_channel_root_counter_top.sv
// ----------------------------------------------------------------------------
// Three-channel root counter
// Three 16-bit counters with mode and target registers, prescaled clock
// sources, reset points, interrupt pulses and bus register access.
// ----------------------------------------------------------------------------
//  Channel    Direction  Payload                                   Handshake
//  i_item     in         operation, reg_address, access_size, data  valid/ready
//  o_result   out        read_data, irq_pulses, bad_access          valid/ready
//  i_cfg      in         period index, period value                 valid/ready
//
//  One item per cycle sustained while results are taken; an input register
//  is followed by the result register, with all counter work in between.
//  Synchronous active-low reset clears the counters, modes, targets and
//  prescalers and loads the default periods. A stalled result holds in the
//  result register while one more item waits in the input register.
// ----------------------------------------------------------------------------
module three_channel_root_counter_top import rcnt_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    rcnt_item_if.sink    i_item,
    rcnt_result_if.source o_result,
    rcnt_cfg_if.sink     i_cfg
);

    logic          r_in_valid;
    t_in_item      r_in;
    logic          r_out_valid;
    t_out_item     r_out;

    logic [15:0]         r_count    [TIMER_COUNT];
    logic [15:0]         r_target   [TIMER_COUNT];
    logic [15:0]         r_mode     [TIMER_COUNT];
    logic [PERIOD_W-1:0] r_prescale [TIMER_COUNT];
    logic [PERIOD_W-1:0] r_period   [TIMER_COUNT];

    logic [15:0]         n_count    [TIMER_COUNT];
    logic [15:0]         n_target   [TIMER_COUNT];
    logic [15:0]         n_mode     [TIMER_COUNT];
    logic [PERIOD_W-1:0] n_prescale [TIMER_COUNT];
    t_out_item           n_out;

    logic out_free;
    logic proc;

    assign out_free       = !r_out_valid || o_result.ready;
    assign proc           = r_in_valid && out_free;
    assign i_item.ready   = !r_in_valid || out_free;
    assign i_cfg.ready    = 1'b1;
    assign o_result.valid = r_out_valid;
    assign o_result.payload = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_item.ready) begin
                r_in_valid <= i_item.valid;
            end
            if (out_free) begin
                r_out_valid <= r_in_valid;
            end
        end
        if (i_item.valid && i_item.ready) begin
            r_in <= i_item.payload;
        end
        if (proc) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int t = 0; t < TIMER_COUNT; t++) begin
            if (!i_rst_n) begin
                r_count[t]    <= '0;
                r_target[t]   <= '0;
                r_mode[t]     <= '0;
                r_prescale[t] <= '0;
                r_period[t]   <= PERIOD_RESET[t];
            end else begin
                if (proc) begin
                    r_count[t]    <= n_count[t];
                    r_target[t]   <= n_target[t];
                    r_mode[t]     <= n_mode[t];
                    r_prescale[t] <= n_prescale[t];
                end
                if (i_cfg.valid && i_cfg.ready && i_cfg.payload.index == 2'(t)) begin
                    r_period[t] <= i_cfg.payload.data;
                end
            end
        end
    end

    logic [1:0]  acc_timer;
    logic [3:0]  acc_off;
    logic        acc_bad;
    logic        t2_halted;
    logic [15:0] rd_word;
    logic [15:0] wr_word;

    assign acc_timer = r_in.reg_address[5:4];
    assign acc_off   = r_in.reg_address[3:0];
    assign acc_bad   = (acc_timer == TIMER_NONE)
                    || !(acc_off == OFF_VALUE || acc_off == OFF_MODE || acc_off == OFF_TARGET);
    // Timer 2 stops while sync is on with sync mode 0 or 3.
    assign t2_halted = r_mode[2][MODE_SYNC_EN]
                    && (r_mode[2][2:1] == 2'd0 || r_mode[2][2:1] == 2'd3);
    assign wr_word   = (r_in.access_size == SIZE_BYTE) ? {8'h00, r_in.write_data[7:0]}
                                                       : r_in.write_data;

    always_comb begin
        logic                alt;
        logic [PERIOD_W:0]   pre_inc;
        logic [PERIOD_W-1:0] per;
        logic                go;
        logic [15:0]         cnt;
        logic [15:0]         point;

        n_count    = r_count;
        n_target   = r_target;
        n_mode     = r_mode;
        n_prescale = r_prescale;
        n_out      = '0;
        rd_word    = '0;
        alt        = 1'b0;
        pre_inc    = '0;
        per        = '0;
        go         = 1'b0;
        cnt        = '0;
        point      = '0;

        case (t_op'(r_in.operation))
            OP_TICK: begin
                for (int t = 0; t < TIMER_COUNT; t++) begin
                    alt     = (t == 2) ? r_mode[t][MODE_SRC_HI] : r_mode[t][MODE_SRC_LO];
                    pre_inc = {1'b0, r_prescale[t]} + 1'b1;
                    per     = (r_period[t] == '0) ? PERIOD_W'(1) : r_period[t];
                    if (alt) begin
                        go            = (pre_inc >= {1'b0, per});
                        n_prescale[t] = go ? '0 : pre_inc[PERIOD_W-1:0];
                    end else begin
                        go            = 1'b1;
                        n_prescale[t] = '0;
                    end
                    cnt = r_count[t];
                    if (go && !(t == 2 && t2_halted)) begin
                        cnt = cnt + 16'd1;
                    end
                    point = r_mode[t][MODE_RESET_TGT] ? r_target[t] : WRAP_POINT;
                    if (cnt == point) begin
                        cnt = '0;
                        n_out.irq_pulses[t] = !r_mode[t][MODE_IRQ_OFF];
                        if (point == WRAP_POINT) begin
                            n_mode[t][MODE_HIT_FFFF] = 1'b1;
                        end else begin
                            n_mode[t][MODE_HIT_TARGET] = 1'b1;
                        end
                    end
                    n_count[t] = cnt;
                end
            end
            OP_READ: begin
                if (acc_bad) begin
                    n_out.bad_access = 1'b1;
                end else begin
                    unique case (acc_off)
                        OFF_VALUE: rd_word = r_count[acc_timer];
                        OFF_MODE: begin
                            rd_word = r_mode[acc_timer];
                            n_mode[acc_timer][MODE_HIT_TARGET] = 1'b0;
                            n_mode[acc_timer][MODE_HIT_FFFF]   = 1'b0;
                        end
                        default:   rd_word = r_target[acc_timer];
                    endcase
                    n_out.read_data = (r_in.access_size == SIZE_BYTE)
                                    ? {8'h00, rd_word[7:0]} : rd_word;
                end
            end
            OP_WRITE: begin
                if (acc_bad) begin
                    n_out.bad_access = 1'b1;
                end else begin
                    unique case (acc_off)
                        OFF_VALUE: n_count[acc_timer] = wr_word;
                        OFF_MODE: begin
                            n_mode[acc_timer]  = wr_word;
                            n_count[acc_timer] = '0;
                        end
                        default:   n_target[acc_timer] = wr_word;
                    endcase
                end
            end
            default: begin
            end
        endcase
    end

    // A bad access never returns data or interrupts.
    a_bad_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.bad_access |-> r_out.read_data == '0 && r_out.irq_pulses == '0)
        else $error("bad access result carries data");

    // A good mode write leaves the addressed counter at zero.
    a_mode_clr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        proc && r_in.operation == OP_WRITE && !acc_bad && acc_off == OFF_MODE
        |=> r_count[$past(acc_timer)] == '0)
        else $error("mode write did not clear counter");

    // Interrupts only appear on results of tick items.
    a_irq_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        proc && r_in.operation != OP_TICK |=> r_out.irq_pulses == '0)
        else $error("interrupt on a bus access");

    // A halted timer 2 never advances on a tick, but wraps at its reset point.
    a_t2_halt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        proc && r_in.operation == OP_TICK && t2_halted && r_count[2] != r_target[2]
        && r_count[2] != WRAP_POINT |=> r_count[2] == $past(r_count[2]))
        else $error("timer 2 advanced while halted");

endmodule

// File: bench/tb_top.sv
// ----------------------------------------------------------------------------
// Three-channel root counter testbench
// Drives tick, bus read and bus write items into the root counter through its
// valid/ready channels and checks each result against a cycle-free model of the
// counters, prescalers, reset points and flags, or typed rows' values. A short
// directed table runs first. Random items follow under several period settings,
// with random sender gaps, receiver stalls and one long receiver hold.
// ----------------------------------------------------------------------------
module tb_top import rcnt_pkg::*; ();

    localparam int LIMIT_CYCLES  = 200000;
    localparam int LONG_HOLD     = 80;
    localparam int DIRECTED_ROWS = 25;

    localparam logic [1:0] OP_IDLE    = 2'd3;
    localparam logic [1:0] SIZE_HALF  = 2'd1;
    localparam logic [1:0] SIZE_WORD  = 2'd2;
    localparam logic [1:0] SIZE_WIDE  = 2'd3;
    localparam logic [3:0] OFF_UNUSED = 4'hC;
    localparam logic [1:0] DIV_TIMER  = 2'd2;

    localparam logic [1:0] CFG_DOT    = 2'd0;
    localparam logic [1:0] CFG_HBLANK = 2'd1;
    localparam logic [1:0] CFG_SLOW   = 2'd2;

    typedef struct packed {
        t_in_item  stim;
        logic      typed;
        t_out_item want;
    } t_row;

    logic i_clk;
    logic i_rst_n;

    rcnt_item_if   item_ch ();
    rcnt_result_if res_ch ();
    rcnt_cfg_if    cfg_ch ();

    three_channel_root_counter_top u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_ch),
        .o_result (res_ch),
        .i_cfg    (cfg_ch)
    );

    // Model state of the three counters.
    logic [15:0]         ctr_value  [TIMER_COUNT];
    logic [15:0]         ctr_target [TIMER_COUNT];
    logic [15:0]         ctr_mode   [TIMER_COUNT];
    logic [PERIOD_W-1:0] ctr_presc  [TIMER_COUNT];
    logic [PERIOD_W-1:0] ctr_period [TIMER_COUNT];

    t_out_item due_results[$];
    int        mismatches = 0;
    logic      long_hold_go = 1'b0;
    logic      long_hold_done = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        repeat (LIMIT_CYCLES) @(posedge i_clk);
        $display("tb_top: errors");
        $finish;
    end

    function automatic logic [5:0] reg_at(input logic [1:0] tmr, input logic [3:0] off);
        return {tmr, off};
    endfunction

    function automatic t_row row(input logic [1:0] op, input logic [5:0] addr,
                                 input logic [1:0] size, input logic [15:0] data,
                                 input logic typed, input logic [15:0] rd,
                                 input logic [2:0] irq, input logic bad);
        t_row r;
        r.stim  = {op, addr, size, data};
        r.typed = typed;
        r.want  = {rd, irq, bad};
        return r;
    endfunction

    // Applies one item to the model counters and returns the result it causes.
    function automatic t_out_item root_counter_eval(input t_in_item it);
        t_out_item           res;
        logic [1:0]          tmr;
        logic [3:0]          off;
        logic [15:0]         data;
        logic [15:0]         point;
        logic [15:0]         rd;
        logic                alt;
        logic                go;
        logic                halted;
        logic [PERIOD_W:0]   nxt;
        logic [PERIOD_W:0]   per;
        res = '0;
        tmr = it.reg_address[5:4];
        off = it.reg_address[3:0];
        data = it.write_data;
        case (it.operation)
            OP_TICK: begin
                halted = ctr_mode[DIV_TIMER][MODE_SYNC_EN] &&
                         (ctr_mode[DIV_TIMER][2:1] == 2'd0 || ctr_mode[DIV_TIMER][2:1] == 2'd3);
                for (int n = 0; n < TIMER_COUNT; n++) begin
                    alt = (n == DIV_TIMER) ? ctr_mode[n][MODE_SRC_HI] : ctr_mode[n][MODE_SRC_LO];
                    if (alt) begin
                        per = (ctr_period[n] == '0) ? (PERIOD_W+1)'(1)
                                                    : {1'b0, ctr_period[n]};
                        nxt = {1'b0, ctr_presc[n]} + 1'b1;
                        if (nxt >= per) begin
                            ctr_presc[n] = '0;
                            go = 1'b1;
                        end else begin
                            ctr_presc[n] = nxt[PERIOD_W-1:0];
                            go = 1'b0;
                        end
                    end else begin
                        ctr_presc[n] = '0;
                        go = 1'b1;
                    end
                    if (go && !(n == DIV_TIMER && halted))
                        ctr_value[n] = ctr_value[n] + 16'd1;
                end
                for (int n = 0; n < TIMER_COUNT; n++) begin
                    point = ctr_mode[n][MODE_RESET_TGT] ? ctr_target[n] : WRAP_POINT;
                    if (ctr_value[n] == point) begin
                        ctr_value[n] = '0;
                        if (!ctr_mode[n][MODE_IRQ_OFF])
                            res.irq_pulses[n] = 1'b1;
                        if (point == WRAP_POINT)
                            ctr_mode[n][MODE_HIT_FFFF] = 1'b1;
                        else
                            ctr_mode[n][MODE_HIT_TARGET] = 1'b1;
                    end
                end
            end
            OP_READ, OP_WRITE: begin
                if (tmr == TIMER_NONE ||
                    (off != OFF_VALUE && off != OFF_MODE && off != OFF_TARGET)) begin
                    res.bad_access = 1'b1;
                end else if (it.operation == OP_READ) begin
                    if (off == OFF_VALUE) begin
                        rd = ctr_value[tmr];
                    end else if (off == OFF_MODE) begin
                        rd = ctr_mode[tmr];
                        ctr_mode[tmr][MODE_HIT_TARGET] = 1'b0;
                        ctr_mode[tmr][MODE_HIT_FFFF] = 1'b0;
                    end else begin
                        rd = ctr_target[tmr];
                    end
                    if (it.access_size == SIZE_BYTE)
                        rd[15:8] = '0;
                    res.read_data = rd;
                end else begin
                    if (it.access_size == SIZE_BYTE)
                        data[15:8] = '0;
                    if (off == OFF_VALUE) begin
                        ctr_value[tmr] = data;
                    end else if (off == OFF_MODE) begin
                        ctr_mode[tmr] = data;
                        ctr_value[tmr] = '0;
                    end else begin
                        ctr_target[tmr] = data;
                    end
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    // Mostly ticks and well-aimed writes, so counters reach their reset points.
    function automatic t_in_item random_item();
        t_in_item   it;
        int         pick;
        logic [1:0] tmr;
        logic [3:0] off;
        pick = $urandom_range(0, 99);
        tmr = ($urandom_range(0, 15) == 0) ? TIMER_NONE : 2'($urandom_range(0, 2));
        case ($urandom_range(0, 2))
            0: off = OFF_VALUE;
            1: off = OFF_MODE;
            default: off = OFF_TARGET;
        endcase
        if ($urandom_range(0, 15) == 0)
            off = 4'($urandom_range(0, 15));
        it.reg_address = {tmr, off};
        it.access_size = 2'($urandom_range(0, 3));
        it.write_data = 16'($urandom);
        if (pick < 50) begin
            it.operation = OP_TICK;
        end else if (pick < 70) begin
            it.operation = OP_READ;
        end else if (pick < 95) begin
            it.operation = OP_WRITE;
            if (tmr != TIMER_NONE) begin
                if (off == OFF_VALUE && $urandom_range(0, 1) == 1) begin
                    it.write_data = ctr_mode[tmr][MODE_RESET_TGT] ?
                                    ctr_target[tmr] - 16'($urandom_range(0, 3)) :
                                    WRAP_POINT - 16'($urandom_range(0, 3));
                end else if (off == OFF_TARGET && $urandom_range(0, 2) != 0) begin
                    it.write_data = 16'($urandom_range(0, 24));
                end else if (off == OFF_MODE) begin
                    if ($urandom_range(0, 1) == 1)
                        it.write_data[MODE_IRQ_OFF] = 1'b0;
                    if (tmr == DIV_TIMER && $urandom_range(0, 3) != 0)
                        it.write_data[MODE_SYNC_EN] = 1'b0;
                end
            end
        end else begin
            it.operation = OP_IDLE;
        end
        return it;
    endfunction

    task automatic offer_item(input t_in_item it, input logic typed, input t_out_item want);
        t_out_item predicted;
        @(negedge i_clk);
        item_ch.valid   <= 1'b1;
        item_ch.payload <= it;
        @(posedge i_clk);
        while (!item_ch.ready) @(posedge i_clk);
        predicted = root_counter_eval(it);
        due_results.push_back(typed ? want : predicted);
    endtask

    task automatic idle(input int cycles);
        repeat (cycles) begin
            @(negedge i_clk);
            item_ch.valid <= 1'b0;
        end
    endtask

    // Holds the sender until every result item has come back.
    task automatic settle();
        idle(1);
        while (due_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_period(input logic [1:0] idx, input logic [PERIOD_W-1:0] val);
        @(negedge i_clk);
        cfg_ch.valid   <= 1'b1;
        cfg_ch.payload <= {idx, val};
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        ctr_period[idx] = val;
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic random_phase(input int count, input int hold_at, input int pause_at);
        int burst_left;
        burst_left = $urandom_range(1, 30);
        for (int i = 0; i < count; i++) begin
            if (i == hold_at)
                long_hold_go = 1'b1;
            if (i == pause_at)
                settle();
            offer_item(random_item(), 1'b0, '0);
            burst_left--;
            if (burst_left == 0) begin
                idle($urandom_range(1, 6));
                burst_left = ($urandom_range(0, 3) == 0) ? 60 : $urandom_range(1, 20);
            end
        end
    endtask

    // Receiver pacing: segments of different stall styles, plus one long hold.
    initial begin : receiver_pace
        int hold_left;
        int seg_left;
        int style;
        hold_left = 0;
        seg_left = 0;
        style = 0;
        res_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (seg_left == 0) begin
                style = $urandom_range(0, 3);
                seg_left = $urandom_range(10, 60);
            end
            seg_left--;
            if (hold_left > 0) begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end else if (long_hold_go && !long_hold_done) begin
                long_hold_done = 1'b1;
                hold_left = LONG_HOLD - 1;
                res_ch.ready <= 1'b0;
            end else begin
                case (style)
                    0: res_ch.ready <= 1'b1;
                    1: res_ch.ready <= 1'($urandom_range(0, 1));
                    2: res_ch.ready <= (seg_left % 3 != 0);
                    default: res_ch.ready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    always @(posedge i_clk) begin : result_check
        t_out_item want;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (due_results.size() == 0) begin
                $display("%0t: unexpected result item %h", $time, res_ch.payload);
                mismatches++;
            end else begin
                want = due_results.pop_front();
                if (res_ch.payload.read_data !== want.read_data) begin
                    $display("%0t: read_data expected %h actual %h",
                             $time, want.read_data, res_ch.payload.read_data);
                    mismatches++;
                end
                if (res_ch.payload.irq_pulses !== want.irq_pulses) begin
                    $display("%0t: irq_pulses expected %b actual %b",
                             $time, want.irq_pulses, res_ch.payload.irq_pulses);
                    mismatches++;
                end
                if (res_ch.payload.bad_access !== want.bad_access) begin
                    $display("%0t: bad_access expected %b actual %b",
                             $time, want.bad_access, res_ch.payload.bad_access);
                    mismatches++;
                end
            end
        end
    end

    initial begin : stimulus
        t_row plan [DIRECTED_ROWS];
        i_rst_n = 1'b0;
        item_ch.valid = 1'b0;
        item_ch.payload = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.payload = '0;
        for (int n = 0; n < TIMER_COUNT; n++) begin
            ctr_value[n] = '0;
            ctr_target[n] = '0;
            ctr_mode[n] = '0;
            ctr_presc[n] = '0;
            ctr_period[n] = PERIOD_RESET[n];
        end

        // After reset every register reads zero; errors and the first wraps
        // can be read straight off the register map.
        plan[0]  = row(OP_READ, reg_at(2'd0, OFF_VALUE), SIZE_WORD, 16'h0000,
                       1'b1, 16'h0000, 3'b000, 1'b0);
        plan[1]  = row(OP_READ, reg_at(2'd2, OFF_MODE), SIZE_HALF, 16'h0000,
                       1'b1, 16'h0000, 3'b000, 1'b0);
        plan[2]  = row(OP_READ, reg_at(TIMER_NONE, OFF_VALUE), SIZE_WORD, 16'h0000,
                       1'b1, 16'h0000, 3'b000, 1'b1);
        plan[3]  = row(OP_READ, reg_at(2'd0, OFF_UNUSED), SIZE_WORD, 16'h0000,
                       1'b1, 16'h0000, 3'b000, 1'b1);
        plan[4]  = row(OP_WRITE, reg_at(TIMER_NONE, OFF_UNUSED), SIZE_WORD, 16'hFFFF,
                       1'b1, 16'h0000, 3'b000, 1'b1);
        plan[5]  = row(OP_TICK, '0, SIZE_BYTE, 16'h0000, 1'b1, 16'h0000, 3'b000, 1'b0);
        plan[6]  = row(OP_WRITE, reg_at(2'd0, OFF_VALUE), SIZE_WORD, 16'hFFFE,
                       1'b1, 16'h0000, 3'b000, 1'b0);
        plan[7]  = row(OP_TICK, '0, SIZE_BYTE, 16'h0000, 1'b1, 16'h0000, 3'b001, 1'b0);
        plan[8]  = row(OP_READ, reg_at(2'd0, OFF_MODE), SIZE_WORD, 16'h0000,
                       1'b1, 16'h1000, 3'b000, 1'b0);
        plan[9]  = row(OP_READ, reg_at(2'd0, OFF_MODE), SIZE_BYTE, 16'h0000,
                       1'b1, 16'h0000, 3'b000, 1'b0);
        plan[10] = row(OP_WRITE, reg_at(2'd1, OFF_TARGET), SIZE_HALF, 16'h0005,
                       1'b0, '0, '0, '0);
        plan[11] = row(OP_WRITE, reg_at(2'd1, OFF_MODE), SIZE_WORD, 16'h0008,
                       1'b0, '0, '0, '0);
        plan[12] = row(OP_WRITE, reg_at(2'd1, OFF_VALUE), SIZE_WORD, 16'h0004,
                       1'b0, '0, '0, '0);
        plan[13] = row(OP_TICK, '0, SIZE_BYTE, 16'h0000, 1'b0, '0, '0, '0);
        plan[14] = row(OP_WRITE, reg_at(2'd2, OFF_MODE), SIZE_WORD, 16'h0001,
                       1'b0, '0, '0, '0);
        plan[15] = row(OP_TICK, '0, SIZE_BYTE, 16'h0000, 1'b0, '0, '0, '0);
        plan[16] = row(OP_WRITE, reg_at(2'd2, OFF_MODE), SIZE_WORD, 16'h0207,
                       1'b0, '0, '0, '0);
        plan[17] = row(OP_TICK, '0, SIZE_BYTE, 16'h0000, 1'b0, '0, '0, '0);
        plan[18] = row(OP_WRITE, reg_at(2'd2, OFF_MODE), SIZE_WORD, 16'h0200,
                       1'b0, '0, '0, '0);
        plan[19] = row(OP_WRITE, reg_at(2'd0, OFF_MODE), SIZE_WORD, 16'h0500,
                       1'b0, '0, '0, '0);
        plan[20] = row(OP_WRITE, reg_at(2'd0, OFF_TARGET), SIZE_BYTE, 16'hABCD,
                       1'b0, '0, '0, '0);
        plan[21] = row(OP_READ, reg_at(2'd0, OFF_TARGET), SIZE_BYTE, 16'h0000,
                       1'b0, '0, '0, '0);
        plan[22] = row(OP_READ, reg_at(2'd0, OFF_TARGET), SIZE_WIDE, 16'h0000,
                       1'b0, '0, '0, '0);
        plan[23] = row(OP_IDLE, reg_at(TIMER_NONE, OFF_UNUSED), SIZE_WIDE, 16'hFFFF,
                       1'b1, 16'h0000, 3'b000, 1'b0);
        plan[24] = row(OP_READ, reg_at(2'd1, OFF_MODE), SIZE_WORD, 16'h0000,
                       1'b0, '0, '0, '0);

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < DIRECTED_ROWS; i++)
            offer_item(plan[i].stim, plan[i].typed, plan[i].want);
        settle();

        // Shortest periods: the alternate sources advance on every tick.
        write_period(CFG_DOT, 12'd1);
        write_period(CFG_HBLANK, 12'd1);
        write_period(CFG_SLOW, 12'd1);
        random_phase(120, -1, 60);
        settle();

        write_period(CFG_DOT, 12'd4095);
        write_period(CFG_HBLANK, 12'd4095);
        write_period(CFG_SLOW, 12'd4095);
        random_phase(100, -1, -1);
        settle();

        // Short random periods so the prescalers roll over often.
        write_period(CFG_DOT, 12'($urandom_range(1, 12)));
        write_period(CFG_HBLANK, 12'($urandom_range(1, 40)));
        write_period(CFG_SLOW, 12'($urandom_range(1, 12)));
        random_phase(200, 40, -1);
        settle();

        repeat (8) @(posedge i_clk);
        if (mismatches == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule
